// File: design/plist_pkg.sv
package plist_pkg;

  localparam int unsigned DATA_W = 32;

  typedef enum logic [1:0] {
    K_HEAD = 2'd0,
    K_TAIL = 2'd1,
    K_POS  = 2'd2,
    K_DEL  = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_EMPTY  = 2'd1,
    ST_BADPOS = 2'd2,
    ST_FULL   = 2'd3
  } status_t;

  // broadcast to every cell of a chain
  typedef struct packed {
    logic              ins;
    logic              del;
    logic [DATA_W-1:0] value;
  } cell_ctrl_t;

endpackage

// File: design/plist_cell.sv
module plist_cell #(
  parameter int IDX = 0,
  parameter int CW  = 7
) (
  input  logic                            clk,
  input  plist_pkg::cell_ctrl_t           ctrl,
  input  logic [CW-1:0]                   bound,
  input  logic [plist_pkg::DATA_W-1:0]    prev_data,
  input  logic [plist_pkg::DATA_W-1:0]    next_data,
  output logic [plist_pkg::DATA_W-1:0]    data
);
  import plist_pkg::*;

  localparam logic [CW-1:0] MY_IDX = CW'(IDX);

  // insert: load at the boundary, shift up above it; delete: pull down from the boundary on
  always_ff @(posedge clk) begin
    if (ctrl.ins) begin
      if (MY_IDX == bound) begin
        data <= ctrl.value;
      end else if (MY_IDX > bound) begin
        data <= prev_data;
      end
    end else if (ctrl.del && (MY_IDX >= bound)) begin
      data <= next_data;
    end
  end

endmodule

// File: design/plist_chain.sv
module plist_chain #(
  parameter int DEPTH = 64,
  parameter int CW    = 7
) (
  input  logic                            clk,
  input  plist_pkg::cell_ctrl_t           ctrl,
  input  logic [CW-1:0]                   bound,
  output logic [plist_pkg::DATA_W-1:0]    first
);
  import plist_pkg::*;

  logic [DATA_W-1:0] cell_q [DEPTH];

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [DATA_W-1:0] prev_d;
    logic [DATA_W-1:0] next_d;

    if (i == 0) begin : g_lo
      assign prev_d = '0;
    end else begin : g_mid_lo
      assign prev_d = cell_q[i-1];
    end

    if (i == DEPTH - 1) begin : g_hi
      assign next_d = '0;
    end else begin : g_mid_hi
      assign next_d = cell_q[i+1];
    end

    plist_cell #(
      .IDX (i),
      .CW  (CW)
    ) u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .bound     (bound),
      .prev_data (prev_d),
      .next_data (next_d),
      .data      (cell_q[i])
    );
  end

  assign first = cell_q[0];

endmodule

// File: design/positional_list_engine.sv
// Positional list engine: an ordered list of up to DEPTH signed 32-bit values.
// Request channel: kind, value and position are taken at a rising edge where
// start is high and busy is low. kind selects insert at head, insert at tail,
// insert at a 1-based position, or delete at a 1-based position.
// Result channel: done is high for exactly one cycle, the cycle after the
// request is taken, with status, length, head_value and tail_value. The
// receiver has no way to stall; a result not taken in that cycle is gone.
// A new request may follow in every cycle while busy is low: the list
// is held twice, in two rows of DEPTH cells, one with the head in cell 0 and
// one with the tail in cell 0. Every cell compares its index against a
// broadcast boundary and shifts from a neighbor in the same cycle, so head
// and tail come straight from cell 0 of each row.
// Reset (rst, synchronous) empties the list and holds busy high for the reset
// cycle; the cell contents are not cleared since only entries below the
// length are ever seen.
module positional_list_engine #(
  parameter int DEPTH = 64
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  logic [1:0]          kind,
  input  logic signed [31:0]  value,
  input  logic [9:0]          position,
  output logic                done,
  output logic [1:0]          status,
  output logic [10:0]         length,
  output logic signed [31:0]  head_value,
  output logic signed [31:0]  tail_value
);
  import plist_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);
  localparam int MW = (CW > 10) ? CW : 10;

  logic [CW-1:0]     count;
  logic [CW-1:0]     count_next;
  status_t           status_r;
  status_t           status_next;
  logic              accept;
  logic              do_ins;
  logic              do_del;
  logic [CW-1:0]     k_idx;
  logic [CW-1:0]     r_bound;
  logic [MW-1:0]     pos_w;
  logic [MW-1:0]     cnt_w;
  logic              full;
  cell_ctrl_t        ctrl;
  logic [DATA_W-1:0] head_q;
  logic [DATA_W-1:0] tail_q;

  assign accept = start && !busy;
  assign pos_w  = MW'(position);
  assign cnt_w  = MW'(count);
  assign full   = (count == CW'(DEPTH));

  always_comb begin
    do_ins      = 1'b0;
    do_del      = 1'b0;
    k_idx       = '0;
    status_next = ST_OK;
    unique case (kind_t'(kind))
      K_HEAD: begin
        if (full) status_next = ST_FULL;
        else do_ins = 1'b1;
      end
      K_TAIL: begin
        if (full) status_next = ST_FULL;
        else begin
          do_ins = 1'b1;
          k_idx  = count;
        end
      end
      K_POS: begin
        if (pos_w == '0) status_next = ST_BADPOS;
        else if (full) status_next = ST_FULL;
        else begin
          do_ins = 1'b1;
          // past the length: append
          k_idx  = (pos_w > cnt_w) ? count : CW'(pos_w - MW'(1));
        end
      end
      K_DEL: begin
        if (count == '0) status_next = ST_EMPTY;
        else if (pos_w == '0 || pos_w > cnt_w) status_next = ST_BADPOS;
        else begin
          do_del = 1'b1;
          k_idx  = CW'(pos_w - MW'(1));
        end
      end
      default: status_next = ST_OK;
    endcase
  end

  // tail-first row counts positions from the tail
  assign r_bound = do_ins ? (count - k_idx) : (count - k_idx - CW'(1));

  assign ctrl.ins   = accept && do_ins;
  assign ctrl.del   = accept && do_del;
  assign ctrl.value = value;

  always_comb begin
    count_next = count;
    if (ctrl.ins) count_next = count + CW'(1);
    else if (ctrl.del) count_next = count - CW'(1);
  end

  plist_chain #(
    .DEPTH (DEPTH),
    .CW    (CW)
  ) u_head_row (
    .clk   (clk),
    .ctrl  (ctrl),
    .bound (k_idx),
    .first (head_q)
  );

  plist_chain #(
    .DEPTH (DEPTH),
    .CW    (CW)
  ) u_tail_row (
    .clk   (clk),
    .ctrl  (ctrl),
    .bound (r_bound),
    .first (tail_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      done     <= 1'b0;
      busy     <= 1'b1;
      status_r <= ST_OK;
    end else begin
      count <= count_next;
      done  <= accept;
      busy  <= 1'b0;
      if (accept) status_r <= status_next;
    end
  end

  assign status     = status_r;
  assign length     = 11'(count);
  assign head_value = (count == '0) ? '0 : head_q;
  assign tail_value = (count == '0) ? '0 : tail_q;

endmodule

// File: design/plist_check.sv
module plist_check #(
  parameter int DEPTH = 64
) (
  input logic               clk,
  input logic               rst,
  input logic               start,
  input logic               busy,
  input logic [1:0]         kind,
  input logic signed [31:0] value,
  input logic [9:0]         position,
  input logic               done,
  input logic [1:0]         status,
  input logic [10:0]        length,
  input logic signed [31:0] head_value,
  input logic signed [31:0] tail_value
);
  import plist_pkg::*;

  // one result for each request, in the cycle after it is taken
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> done)
    else $error("request without result");

  a_no_stray_result: assert property (@(posedge clk) disable iff (rst)
    !(start && !busy) |=> !done)
    else $error("result without request");

  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    (done && length == 11'd0) |-> (head_value == 32'sd0 && tail_value == 32'sd0))
    else $error("empty list shows nonzero head or tail");

  a_fail_keeps_length: assert property (@(posedge clk) disable iff (rst)
    (done && $past(done) && status != ST_OK) |-> (length == $past(length)))
    else $error("failed request changed the length");

  a_length_bound: assert property (@(posedge clk) disable iff (rst)
    done |-> (length <= 11'(DEPTH)) && (status != ST_EMPTY || length == 11'd0))
    else $error("length out of range");

endmodule

bind positional_list_engine plist_check #(.DEPTH(DEPTH)) u_plist_check (.*);
